[sv/ates_pkg.sv]
package ates_pkg;

   // Input transaction: one terminal byte or one cell read.
   typedef struct packed {
      logic       mode;
      logic [7:0] byte_value;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_type;

   // Result transaction: cursor after the step, status and the cell read.
   typedef struct packed {
      logic [6:0] cursor_col;
      logic [4:0] cursor_row;
      logic [1:0] status;
      logic [7:0] cell_char;
      logic       cell_fg_set;
      logic [7:0] cell_fg_index;
      logic       cell_bg_set;
      logic [7:0] cell_bg_index;
   } rsp_type;

   // One stored character cell.
   typedef struct packed {
      logic [7:0] ch;
      logic       fg_set;
      logic [7:0] fg_index;
      logic       bg_set;
      logic [7:0] bg_index;
   } cell_type;

   localparam logic MODE_FEED = 1'b0;
   localparam logic MODE_READ = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_SEQ  = 2'd1;
   localparam logic [1:0] STATUS_BAD_CHAR = 2'd2;

   localparam logic [7:0] CHAR_ESC      = 8'h1B;
   localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_DOT      = 8'h2E;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_SEMI     = 8'h3B;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_TWO      = 8'h32;
   localparam logic [7:0] CHAR_THREE    = 8'h33;
   localparam logic [7:0] CHAR_FOUR     = 8'h34;
   localparam logic [7:0] CHAR_FIVE     = 8'h35;
   localparam logic [7:0] CHAR_EIGHT    = 8'h38;
   localparam logic [7:0] CHAR_NINE     = 8'h39;
   localparam logic [7:0] CHAR_H        = 8'h48;
   localparam logic [7:0] CHAR_J        = 8'h4A;
   localparam logic [7:0] CHAR_K        = 8'h4B;
   localparam logic [7:0] CHAR_M        = 8'h6D;
   localparam logic [7:0] PRINT_LOW     = 8'd32;
   localparam logic [7:0] PRINT_END     = 8'd127;

   localparam cell_type CELL_BLANK = '{ch: CHAR_SPACE, fg_set: 1'b0, fg_index: 8'd0,
                                       bg_set: 1'b0, bg_index: 8'd0};

endpackage

[sv/ansi_text_screen_engine.sv]
// Plain bytes, newline without scroll and cursor moves answer straight from the idle state; a
// cell read passes through a read state and a colour change through one read-modify-write of
// the cell memory; a scroll or a clear screen sweeps all ROWS*COLUMNS cells and a clear line
// sweeps COLUMNS cells (one cell per cycle). Throughput: one transaction at a time; the cell
// memory has one write port and one registered read port. Reset: synchronous; a clearing pass
// writes a blank to every cell while no transaction is accepted.
module ansi_text_screen_engine #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ates_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ates_pkg::rsp_type rsp_data
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_RMW, S_READ, S_COPY, S_COPY_END
   } state_type;

   typedef enum logic [3:0] {
      PH_GROUND, PH_ESC, PH_CSI, PH_ZERO, PH_TWO,
      PH_FG1, PH_FG2, PH_FG3, PH_FG4, PH_FGNUM,
      PH_BG1, PH_BG2, PH_BG3, PH_BG4, PH_BGNUM
   } phase_type;

   typedef enum logic [2:0] {
      A_NONE, A_SCROLL, A_RMW_ZERO, A_RMW_FG, A_RMW_BG, A_CLEAR, A_LINE
   } action_type;

   // Cell memory.
   ates_pkg::cell_type mem [CELLS];
   ates_pkg::cell_type rd_data_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_wa;
   logic [AW-1:0]      mem_ra;
   ates_pkg::cell_type mem_wd;

   // Control and architectural state.
   state_type          state_ff;
   logic [AW-1:0]      sweep_ff;
   logic [AW-1:0]      sweep_end_ff;
   logic [AW-1:0]      copy_lim_ff;
   logic [7:0]         fill_ff;
   logic               cp_v_ff;
   logic [AW-1:0]      cp_addr_ff;
   logic               cp_over_ff;
   logic [CW-1:0]      col_ff;
   logic [RW-1:0]      row_ff;
   logic               pen_fg_set_ff;
   logic [7:0]         pen_fg_index_ff;
   logic               pen_bg_set_ff;
   logic [7:0]         pen_bg_index_ff;
   phase_type          phase_ff;
   logic [7:0]         acc_ff;
   action_type         rmw_op_ff;
   logic [AW-1:0]      rmw_addr_ff;
   ates_pkg::rsp_type  hold_ff;
   logic               hold_pend_ff;
   logic               rd_range_ff;
   logic               rsp_valid_ff;
   ates_pkg::rsp_type  rsp_data_ff;

   // Decode results for the byte being fed.
   phase_type          phase_in;
   logic [7:0]         acc_in;
   logic [1:0]         st_c;
   logic [CW-1:0]      col_in;
   logic [RW-1:0]      row_in;
   logic               pen_fg_set_in;
   logic [7:0]         pen_fg_index_in;
   logic               pen_bg_set_in;
   logic [7:0]         pen_bg_index_in;
   action_type         act_c;
   logic               put_c;

   logic               accept;
   logic [AW-1:0]      here;
   logic [AW-1:0]      row_base;
   logic               rd_in_range;
   logic [AW-1:0]      rd_addr;
   logic               copy_over;
   logic [AW-1:0]      copy_ra;
   logic [7:0]         b;
   logic               is_digit;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign here     = AW'(AW'(row_ff) * AW'(COLUMNS) + AW'(col_ff));
   assign row_base = AW'(AW'(row_ff) * AW'(COLUMNS));
   assign rd_in_range = (int'(req_data.read_row) < ROWS) && (int'(req_data.read_col) < COLUMNS);
   assign rd_addr  = AW'(AW'(req_data.read_row) * AW'(COLUMNS) + AW'(req_data.read_col));
   assign copy_over = (sweep_ff >= copy_lim_ff);
   assign copy_ra  = copy_over ? sweep_ff : AW'(sweep_ff + AW'(COLUMNS));
   assign b        = req_data.byte_value;
   assign is_digit = (b >= ates_pkg::CHAR_ZERO) && (b <= ates_pkg::CHAR_NINE);

   // Escape parser and cursor update for one fed byte.
   always_comb begin
      phase_in        = PH_GROUND;
      acc_in          = acc_ff;
      st_c            = ates_pkg::STATUS_OK;
      col_in          = col_ff;
      row_in          = row_ff;
      pen_fg_set_in   = pen_fg_set_ff;
      pen_fg_index_in = pen_fg_index_ff;
      pen_bg_set_in   = pen_bg_set_ff;
      pen_bg_index_in = pen_bg_index_ff;
      act_c           = A_NONE;
      put_c           = 1'b0;
      case (phase_ff)
         PH_GROUND: begin
            if (b == ates_pkg::CHAR_ESC) begin
               phase_in = PH_ESC;
            end else if (b == ates_pkg::CHAR_NEWLINE ||
                         (b >= ates_pkg::PRINT_LOW && b < ates_pkg::PRINT_END)) begin
               put_c = (b != ates_pkg::CHAR_NEWLINE);
               if (put_c && col_ff != CW'(COLUMNS - 1)) begin
                  col_in = CW'(col_ff + 1'b1);
               end else begin
                  col_in = '0;
                  if (row_ff == RW'(ROWS - 1)) begin
                     act_c = A_SCROLL;
                  end else begin
                     row_in = RW'(row_ff + 1'b1);
                  end
               end
            end else begin
               st_c = ates_pkg::STATUS_BAD_CHAR;
            end
         end
         PH_ESC: begin
            if (b == ates_pkg::CHAR_LBRACKET) phase_in = PH_CSI;
            else st_c = ates_pkg::STATUS_BAD_SEQ;
         end
         PH_CSI: begin
            if (b == ates_pkg::CHAR_H) begin
               col_in = '0;
               row_in = '0;
            end else if (b == ates_pkg::CHAR_ZERO) phase_in = PH_ZERO;
            else if (b == ates_pkg::CHAR_TWO) phase_in = PH_TWO;
            else if (b == ates_pkg::CHAR_THREE) phase_in = PH_FG1;
            else if (b == ates_pkg::CHAR_FOUR) phase_in = PH_BG1;
            else st_c = ates_pkg::STATUS_BAD_SEQ;
         end
         PH_ZERO: begin
            if (b == ates_pkg::CHAR_M) begin
               act_c         = A_RMW_ZERO;
               pen_fg_set_in = 1'b0;
               pen_bg_set_in = 1'b0;
            end else begin
               st_c = ates_pkg::STATUS_BAD_SEQ;
            end
         end
         PH_TWO: begin
            if (b == ates_pkg::CHAR_J) begin
               act_c  = A_CLEAR;
               col_in = '0;
               row_in = '0;
            end else if (b == ates_pkg::CHAR_K) begin
               act_c  = A_LINE;
               col_in = '0;
            end else begin
               st_c = ates_pkg::STATUS_BAD_SEQ;
            end
         end
         PH_FG1: begin
            if (b == ates_pkg::CHAR_EIGHT) phase_in = PH_FG2;
            else st_c = ates_pkg::STATUS_BAD_SEQ;
         end
         PH_BG1: begin
            if (b == ates_pkg::CHAR_EIGHT) phase_in = PH_BG2;
            else st_c = ates_pkg::STATUS_BAD_SEQ;
         end
         PH_FG2: begin
            if (b == ates_pkg::CHAR_SEMI) phase_in = PH_FG3;
            else st_c = ates_pkg::STATUS_BAD_SEQ;
         end
         PH_BG2: begin
            if (b == ates_pkg::CHAR_SEMI) phase_in = PH_BG3;
            else st_c = ates_pkg::STATUS_BAD_SEQ;
         end
         PH_FG3: begin
            if (b == ates_pkg::CHAR_FIVE) phase_in = PH_FG4;
            else st_c = ates_pkg::STATUS_BAD_SEQ;
         end
         PH_BG3: begin
            if (b == ates_pkg::CHAR_FIVE) phase_in = PH_BG4;
            else st_c = ates_pkg::STATUS_BAD_SEQ;
         end
         PH_FG4, PH_BG4: begin
            if (b == ates_pkg::CHAR_SEMI) begin
               phase_in = (phase_ff == PH_FG4) ? PH_FGNUM : PH_BGNUM;
               acc_in   = '0;
            end else begin
               st_c = ates_pkg::STATUS_BAD_SEQ;
            end
         end
         PH_FGNUM, PH_BGNUM: begin
            if (is_digit) begin
               acc_in   = 8'(acc_ff * 4'd10 + (b - ates_pkg::CHAR_ZERO));
               phase_in = phase_ff;
            end else if (b == ates_pkg::CHAR_M) begin
               if (phase_ff == PH_FGNUM) begin
                  act_c           = A_RMW_FG;
                  pen_fg_set_in   = 1'b1;
                  pen_fg_index_in = acc_ff;
               end else begin
                  act_c           = A_RMW_BG;
                  pen_bg_set_in   = 1'b1;
                  pen_bg_index_in = acc_ff;
               end
            end else begin
               st_c = ates_pkg::STATUS_BAD_SEQ;
            end
         end
         default: begin
            st_c = ates_pkg::STATUS_BAD_SEQ;
         end
      endcase
   end

   // Memory port selection.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = sweep_ff;
      mem_wd = ates_pkg::CELL_BLANK;
      mem_ra = here;
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
         end
         S_IDLE: begin
            if (accept && req_data.mode == ates_pkg::MODE_READ) begin
               mem_ra = rd_addr;
            end else if (accept && put_c) begin
               mem_we = 1'b1;
               mem_wa = here;
               mem_wd = '{ch: b, fg_set: pen_fg_set_ff, fg_index: pen_fg_index_ff,
                          bg_set: pen_bg_set_ff, bg_index: pen_bg_index_ff};
            end
         end
         S_RMW: begin
            mem_we = 1'b1;
            mem_wa = rmw_addr_ff;
            mem_wd = rd_data_ff;
            case (rmw_op_ff)
               A_RMW_ZERO: begin
                  mem_wd.fg_set = 1'b0;
                  mem_wd.bg_set = 1'b0;
               end
               A_RMW_FG: begin
                  mem_wd.fg_set   = 1'b1;
                  mem_wd.fg_index = acc_ff;
               end
               A_RMW_BG: begin
                  mem_wd.bg_set   = 1'b1;
                  mem_wd.bg_index = acc_ff;
               end
               default: begin
                  mem_wd = rd_data_ff;
               end
            endcase
         end
         S_COPY, S_COPY_END: begin
            mem_we = cp_v_ff;
            mem_wa = cp_addr_ff;
            mem_wd = rd_data_ff;
            if (cp_over_ff) mem_wd.ch = fill_ff;
            mem_ra = copy_ra;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Cell memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_data_ff <= mem[mem_ra];
   end

   // Sequencer, cursor, pen, parser and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         sweep_ff        <= '0;
         cp_v_ff         <= 1'b0;
         col_ff          <= '0;
         row_ff          <= '0;
         pen_fg_set_ff   <= 1'b0;
         pen_fg_index_ff <= '0;
         pen_bg_set_ff   <= 1'b0;
         pen_bg_index_ff <= '0;
         phase_ff        <= PH_GROUND;
         acc_ff          <= '0;
         hold_pend_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         cp_v_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               if (sweep_ff == AW'(CELLS - 1)) begin
                  state_ff <= S_IDLE;
                  if (hold_pend_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_data_ff  <= hold_ff;
                     hold_pend_ff <= 1'b0;
                  end
               end else begin
                  sweep_ff <= AW'(sweep_ff + 1'b1);
               end
            end
            S_IDLE: begin
               if (accept) begin
                  hold_ff <= '0;
                  if (req_data.mode == ates_pkg::MODE_READ) begin
                     hold_ff.cursor_col <= 7'(col_ff);
                     hold_ff.cursor_row <= 5'(row_ff);
                     rd_range_ff        <= rd_in_range;
                     state_ff           <= S_READ;
                  end else begin
                     col_ff          <= col_in;
                     row_ff          <= row_in;
                     pen_fg_set_ff   <= pen_fg_set_in;
                     pen_fg_index_ff <= pen_fg_index_in;
                     pen_bg_set_ff   <= pen_bg_set_in;
                     pen_bg_index_ff <= pen_bg_index_in;
                     phase_ff        <= phase_in;
                     acc_ff          <= acc_in;
                     hold_ff.cursor_col <= 7'(col_in);
                     hold_ff.cursor_row <= 5'(row_in);
                     hold_ff.status     <= st_c;
                     rmw_op_ff          <= act_c;
                     rmw_addr_ff        <= here;
                     case (act_c)
                        A_NONE: begin
                           rsp_valid_ff <= 1'b1;
                           rsp_data_ff  <= '{cursor_col: 7'(col_in), cursor_row: 5'(row_in),
                                             status: st_c, default: '0};
                        end
                        A_SCROLL: begin
                           state_ff     <= S_COPY;
                           sweep_ff     <= '0;
                           sweep_end_ff <= AW'(CELLS - 1);
                           copy_lim_ff  <= AW'(CELLS - COLUMNS);
                           fill_ff      <= ates_pkg::CHAR_DOT;
                        end
                        A_RMW_ZERO, A_RMW_FG, A_RMW_BG: begin
                           state_ff <= S_RMW;
                        end
                        A_CLEAR: begin
                           state_ff     <= S_CLEAR;
                           sweep_ff     <= '0;
                           hold_pend_ff <= 1'b1;
                        end
                        A_LINE: begin
                           state_ff     <= S_COPY;
                           sweep_ff     <= row_base;
                           sweep_end_ff <= AW'(row_base + AW'(COLUMNS - 1));
                           copy_lim_ff  <= '0;
                           fill_ff      <= ates_pkg::CHAR_SPACE;
                        end
                        default: begin
                           state_ff <= S_IDLE;
                        end
                     endcase
                  end
               end
            end
            S_READ: begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= hold_ff;
               if (rd_range_ff) begin
                  rsp_data_ff.cell_char     <= rd_data_ff.ch;
                  rsp_data_ff.cell_fg_set   <= rd_data_ff.fg_set;
                  rsp_data_ff.cell_fg_index <= rd_data_ff.fg_index;
                  rsp_data_ff.cell_bg_set   <= rd_data_ff.bg_set;
                  rsp_data_ff.cell_bg_index <= rd_data_ff.bg_index;
               end
               state_ff <= S_IDLE;
            end
            S_RMW: begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= hold_ff;
               state_ff     <= S_IDLE;
            end
            S_COPY: begin
               // Read one cell ahead of the write-back stage.
               cp_v_ff    <= 1'b1;
               cp_addr_ff <= sweep_ff;
               cp_over_ff <= copy_over;
               if (sweep_ff == sweep_end_ff) begin
                  state_ff <= S_COPY_END;
               end else begin
                  sweep_ff <= AW'(sweep_ff + 1'b1);
               end
            end
            S_COPY_END: begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= hold_ff;
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;

   localparam int COLS = 80;
   localparam int LINES = 24;
   localparam int IDLE_LIMIT = 20000;

   typedef enum logic [3:0] {
      P_GROUND, P_ESC, P_CSI, P_ZERO, P_TWO,
      P_FG1, P_FG2, P_FG3, P_FG4, P_FGNUM,
      P_BG1, P_BG2, P_BG3, P_BG4, P_BGNUM
   } phase_type;

   // Screen predictor and queue of expected result transactions.
   class screen_scoreboard;
      ates_pkg::cell_type grid[LINES*COLS];
      logic [6:0] ccol;
      logic [4:0] crow;
      logic       fg_on, bg_on;
      logic [7:0] fg_idx, bg_idx, acc;
      phase_type  phase;
      ates_pkg::rsp_type pending[$];
      int         errors;
      int         checked;

      function new();
         foreach (grid[k]) grid[k] = ates_pkg::CELL_BLANK;
         ccol = 0; crow = 0; fg_on = 0; bg_on = 0;
         fg_idx = 0; bg_idx = 0; acc = 0; phase = P_GROUND;
         errors = 0; checked = 0;
      endfunction

      function int spot();
         return int'(crow) * COLS + int'(ccol);
      endfunction

      // Interpret one fed byte; returns the status code.
      function logic [1:0] feed_byte(logic [7:0] b);
         phase_type ph;
         logic [1:0] st;
         int line;
         ph = phase;
         st = ates_pkg::STATUS_OK;
         line = crow;
         phase = P_GROUND;
         case (ph)
            P_GROUND: begin
               if (b == ates_pkg::CHAR_ESC) phase = P_ESC;
               else if (b == ates_pkg::CHAR_NEWLINE) begin
                  ccol = 0; line++;
               end else if (b >= ates_pkg::PRINT_LOW && b < ates_pkg::PRINT_END) begin
                  grid[spot()] = '{ch: b, fg_set: fg_on, fg_index: fg_idx,
                                   bg_set: bg_on, bg_index: bg_idx};
                  if (ccol == COLS - 1) begin
                     ccol = 0; line++;
                  end else ccol++;
               end else st = ates_pkg::STATUS_BAD_CHAR;
            end
            P_ESC: if (b == ates_pkg::CHAR_LBRACKET) phase = P_CSI;
               else st = ates_pkg::STATUS_BAD_SEQ;
            P_CSI: begin
               if (b == ates_pkg::CHAR_H) begin
                  ccol = 0; line = 0;
               end else if (b == ates_pkg::CHAR_ZERO) phase = P_ZERO;
               else if (b == ates_pkg::CHAR_TWO) phase = P_TWO;
               else if (b == ates_pkg::CHAR_THREE) phase = P_FG1;
               else if (b == ates_pkg::CHAR_FOUR) phase = P_BG1;
               else st = ates_pkg::STATUS_BAD_SEQ;
            end
            P_ZERO: begin
               if (b == ates_pkg::CHAR_M) begin
                  grid[spot()].fg_set = 0;
                  grid[spot()].bg_set = 0;
                  fg_on = 0; bg_on = 0;
               end else st = ates_pkg::STATUS_BAD_SEQ;
            end
            P_TWO: begin
               if (b == ates_pkg::CHAR_J) begin
                  foreach (grid[k]) grid[k] = ates_pkg::CELL_BLANK;
                  ccol = 0; line = 0;
               end else if (b == ates_pkg::CHAR_K) begin
                  for (int c = 0; c < COLS; c++)
                     grid[int'(crow)*COLS + c].ch = ates_pkg::CHAR_SPACE;
                  ccol = 0;
               end else st = ates_pkg::STATUS_BAD_SEQ;
            end
            P_FG1, P_BG1: if (b == ates_pkg::CHAR_EIGHT) phase = phase_type'(ph + 1);
               else st = ates_pkg::STATUS_BAD_SEQ;
            P_FG2, P_BG2: if (b == ates_pkg::CHAR_SEMI) phase = phase_type'(ph + 1);
               else st = ates_pkg::STATUS_BAD_SEQ;
            P_FG3, P_BG3: if (b == ates_pkg::CHAR_FIVE) phase = phase_type'(ph + 1);
               else st = ates_pkg::STATUS_BAD_SEQ;
            P_FG4, P_BG4: begin
               if (b == ates_pkg::CHAR_SEMI) begin
                  phase = phase_type'(ph + 1); acc = 0;
               end else st = ates_pkg::STATUS_BAD_SEQ;
            end
            default: begin
               if (b >= ates_pkg::CHAR_ZERO && b <= ates_pkg::CHAR_NINE) begin
                  acc = acc * 8'd10 + (b - ates_pkg::CHAR_ZERO);
                  phase = ph;
               end else if (b == ates_pkg::CHAR_M) begin
                  if (ph == P_FGNUM) begin
                     grid[spot()].fg_set = 1; grid[spot()].fg_index = acc;
                     fg_on = 1; fg_idx = acc;
                  end else begin
                     grid[spot()].bg_set = 1; grid[spot()].bg_index = acc;
                     bg_on = 1; bg_idx = acc;
                  end
               end else st = ates_pkg::STATUS_BAD_SEQ;
            end
         endcase
         // Scroll up one row once the cursor passes the bottom.
         if (line >= LINES) begin
            for (int k = 0; k < (LINES-1)*COLS; k++) grid[k] = grid[k+COLS];
            for (int c = 0; c < COLS; c++) grid[(LINES-1)*COLS + c].ch = ates_pkg::CHAR_DOT;
            line = LINES - 1;
         end
         crow = line[4:0];
         return st;
      endfunction

      // Note an accepted input transaction.
      function void note_request(ates_pkg::req_type r);
         ates_pkg::rsp_type e;
         e = '0;
         if (r.mode == ates_pkg::MODE_FEED) e.status = feed_byte(r.byte_value);
         else if (r.read_row < LINES && r.read_col < COLS) begin
            e.cell_char = grid[int'(r.read_row)*COLS + int'(r.read_col)].ch;
            e.cell_fg_set = grid[int'(r.read_row)*COLS + int'(r.read_col)].fg_set;
            e.cell_fg_index = grid[int'(r.read_row)*COLS + int'(r.read_col)].fg_index;
            e.cell_bg_set = grid[int'(r.read_row)*COLS + int'(r.read_col)].bg_set;
            e.cell_bg_index = grid[int'(r.read_row)*COLS + int'(r.read_col)].bg_index;
         end
         e.cursor_col = ccol;
         e.cursor_row = crow;
         pending.push_back(e);
      endfunction

      // Compare one result transaction with the oldest expectation.
      function void check_result(ates_pkg::rsp_type a);
         ates_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $realtime, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (a.cursor_col !== e.cursor_col) report("cursor_col", e.cursor_col, a.cursor_col);
         if (a.cursor_row !== e.cursor_row) report("cursor_row", e.cursor_row, a.cursor_row);
         if (a.status !== e.status) report("status", e.status, a.status);
         if (a.cell_char !== e.cell_char) report("cell_char", e.cell_char, a.cell_char);
         if (a.cell_fg_set !== e.cell_fg_set) report("cell_fg_set", e.cell_fg_set, a.cell_fg_set);
         if (a.cell_fg_index !== e.cell_fg_index)
            report("cell_fg_index", e.cell_fg_index, a.cell_fg_index);
         if (a.cell_bg_set !== e.cell_bg_set) report("cell_bg_set", e.cell_bg_set, a.cell_bg_set);
         if (a.cell_bg_index !== e.cell_bg_index)
            report("cell_bg_index", e.cell_bg_index, a.cell_bg_index);
      endfunction

      function void report(string f, logic [7:0] e, logic [7:0] a);
         $display("%0t: %s expected %0d actual %0d", $realtime, f, e, a);
         errors++;
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   ates_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   ates_pkg::rsp_type rsp_data;

   screen_scoreboard board = new();
   ates_pkg::req_type stim[$];
   int      idle_cycles = 0;
   bit      stim_done = 0;
   bit      hold_off = 0;
   int      reads_sent = 0;

   ansi_text_screen_engine i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Monitor both channels at the rising edge; watchdog on idle cycles.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_request(req_data);
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   // Receiver stall pattern, with one long hold-off while the sender keeps going.
   initial begin
      int mode_sel;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 0;
            repeat (400) @(negedge clock);
            hold_off = 0;
         end
         mode_sel = $urandom_range(0, 3);
         repeat ($urandom_range(5, 60)) begin
            case (mode_sel)
               0: rsp_ready <= 1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= ($urandom_range(0, 1) != 0);
               default: rsp_ready <= ($urandom_range(0, 5) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   function automatic ates_pkg::req_type feed_item(logic [7:0] b);
      ates_pkg::req_type r;
      r = '0;
      r.mode = ates_pkg::MODE_FEED;
      r.byte_value = b;
      r.read_row = 5'($urandom);
      r.read_col = 7'($urandom);
      return r;
   endfunction

   function automatic ates_pkg::req_type read_item(logic [4:0] row, logic [6:0] col);
      ates_pkg::req_type r;
      r.mode = ates_pkg::MODE_READ;
      r.byte_value = 8'($urandom);
      r.read_row = row;
      r.read_col = col;
      return r;
   endfunction

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) stim.push_back(feed_item(s[i]));
   endtask

   // Random escape sequence, mostly well formed, sometimes broken.
   task automatic push_sequence();
      int kind;
      string num;
      kind = $urandom_range(0, 9);
      num = $sformatf("%0d", $urandom_range(0, 999));
      if ($urandom_range(0, 7) == 0) num = "";
      case (kind)
         0: push_text("\033[0m");
         1, 2: push_text({"\033[38;5;", num, "m"});
         3, 4: push_text({"\033[48;5;", num, "m"});
         5: push_text("\033[H");
         6: push_text("\033[2K");
         7: if ($urandom_range(0, 3) == 0) push_text("\033[2J");
            else push_text({"\033[38;5;", num, "m"});
         default: begin
            string full;
            int cut;
            full = {"\033[38;5;", num, "m"};
            cut = $urandom_range(1, full.len() - 1);
            push_text(full.substr(0, cut - 1));
            stim.push_back(feed_item(8'($urandom)));
         end
      endcase
   endtask

   // Sender: bursts of random length with random gaps.
   task automatic send_all();
      int gap;
      while (stim.size() > 0) begin
         repeat ($urandom_range(1, 30)) begin
            if (stim.size() == 0) break;
            req_valid <= 1;
            req_data <= stim.pop_front();
            @(posedge clock);
            while (!req_ready) @(posedge clock);
            @(negedge clock);
         end
         gap = ($urandom_range(0, 2) != 0) ? $urandom_range(0, 8) : 0;
         // Drop req_valid before the caller can queue more transactions.
         if (stim.size() == 0) gap = gap + 1;
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   initial begin
      int wait_cycles;
      repeat (10) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: edges of fields, each escape, failures and reads.
      stim.push_back(read_item(0, 0));
      stim.push_back(read_item(23, 79));
      stim.push_back(read_item(5'h1F, 7'h7F));
      push_text("\033[38;5;300mA\033[48;5;mB");
      push_text("\033[0m");
      stim.push_back(feed_item(8'h00));
      stim.push_back(feed_item(8'hFF));
      stim.push_back(feed_item(8'h7F));
      push_text("\033\033x");
      stim.push_back(read_item(0, 0));
      stim.push_back(read_item(0, 1));
      push_text("\033[2K\033[9\033[H\033[2J");
      send_all();

      // Random stream with fills to force wrapping and scrolling.
      hold_off = 1;
      while (stim.size() + board.checked < 830) begin
         int pick;
         pick = $urandom_range(0, 19);
         if (pick < 8) stim.push_back(feed_item(8'($urandom_range(32, 126))));
         else if (pick < 10) stim.push_back(feed_item(ates_pkg::CHAR_NEWLINE));
         else if (pick < 13) push_sequence();
         else if (pick < 17) begin
            stim.push_back(read_item(5'($urandom_range(0, 23)), 7'($urandom_range(0, 79))));
            reads_sent++;
         end else if (pick < 18) stim.push_back(read_item(5'($urandom), 7'($urandom)));
         else if (pick < 19) stim.push_back(feed_item(8'($urandom)));
         else repeat (3) stim.push_back(feed_item(ates_pkg::CHAR_NEWLINE));
         if (stim.size() > 60) send_all();
      end
      send_all();

      // Drain.
      wait_cycles = 0;
      while (board.pending.size() > 0 && wait_cycles < 200000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (3000) @(negedge clock);
      $display("tb: checked %0d results, %0d random cell reads, through wraps, scrolls",
               board.checked, reads_sent);
      $display("tb: escape sequences, broken sequences and a long receiver stall.");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule

[sim.f]
sv/ates_pkg.sv
sv/ansi_text_screen_engine.sv
sim/tb.sv
